[src/highpass_dither_requantizer_core_macros.svh]
// Assertion macros shared by the requantizer RTL.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef HIGHPASS_DITHER_REQUANTIZER_CORE_MACROS_SVH
`define HIGHPASS_DITHER_REQUANTIZER_CORE_MACROS_SVH

// The condition holds at every clock edge outside of reset.
`define HDRQ_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define HDRQ_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[src/hdrq_pkg.sv]
// Package for the high-pass dither requantizer: register widths, fixed-point
// formats, register indexes, the noise seed and the xorshift step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdrq_pkg;

  // Default structural parameters.
  localparam int DEF_DELAY_TAPS  = 4;
  localparam int DEF_DITHER_BITS = 16;
  localparam int DEF_SAMPLE_BITS = 24;

  // Configuration register formats.
  localparam int SCALE_W    = 40;
  localparam int SCALE_FRAC = 16;
  localparam int RECIP_W    = 38;
  localparam int RECIP_FRAC = 40;
  localparam int REG_W      = 40;
  localparam int CHUNK_W    = REG_W / 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64'd2147483648);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(64'd33554432);

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 1'b1;

  // Noise generator seed.
  localparam logic [31:0] NOISE_SEED = 32'h2545F491;

  // Control word from the sequencer to the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;    // register a new partial product
    logic acc_load;  // accumulator takes the partial product
    logic acc_add;   // accumulator adds the partial product shifted by one chunk
  } mac_ctrl_t;

  // One step of the xorshift32 generator (shifts 13, 17, 5).
  function automatic logic [31:0] xorshift32(input logic [31:0] g);
    logic [31:0] r;
    r = g ^ (g << 13);
    r = r ^ (r >> 17);
    r = r ^ (r << 5);
    return r;
  endfunction

endpackage

`default_nettype wire

[src/hdrq_mac.sv]
// Shared multiply-accumulate unit (uses hdrq_pkg): a signed operand times one
// unsigned chunk per mul_en cycle; partial product, accumulator are registered.
`timescale 1ns / 1ps
`default_nettype none

module hdrq_mac
  import hdrq_pkg::*;
#(
  parameter int A_W = 26
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [A_W-1:0]      a_i,
  input  logic [CHUNK_W-1:0]         chunk_i,
  output logic signed [A_W+REG_W-1:0] acc_o
);

  localparam int PPW = A_W + CHUNK_W + 1;
  localparam int AW  = A_W + REG_W;

  logic signed [PPW-1:0] pp_q, pp_d;
  logic signed [AW-1:0]  acc_q;

  // The chunk is zero-extended so that the product stays signed.
  assign pp_d = PPW'(a_i) * PPW'($signed({1'b0, chunk_i}));

  // Partial product register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q <= '0;
    end else if (ctrl_i.mul_en) begin
      pp_q <= pp_d;
    end
  end

  // Accumulator: the low chunk product is loaded, the high one added one chunk up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_load) begin
      acc_q <= AW'(pp_q);
    end else if (ctrl_i.acc_add) begin
      acc_q <= acc_q + (AW'(pp_q) <<< CHUNK_W);
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[src/hdrq_dither.sv]
// Dither source: xorshift32 noise generator and the per-channel delay lines
// of past dither words. Uses hdrq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "highpass_dither_requantizer_core_macros.svh"

module hdrq_dither
  import hdrq_pkg::*;
#(
  parameter int DELAY_TAPS  = DEF_DELAY_TAPS,
  parameter int DITHER_BITS = DEF_DITHER_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   chan_i,
  output logic [DITHER_BITS-1:0] cur_o,
  output logic [DITHER_BITS-1:0] old_o
);

  logic [31:0]            gen_q;
  logic [31:0]            gen_next;
  logic [DITHER_BITS-1:0] hist_l_q [DELAY_TAPS];
  logic [DITHER_BITS-1:0] hist_r_q [DELAY_TAPS];

  // The fresh dither word is the top of the stepped generator.
  assign gen_next = xorshift32(gen_q);
  assign cur_o    = gen_next[31 -: DITHER_BITS];
  assign old_o    = chan_i ? hist_r_q[DELAY_TAPS-1] : hist_l_q[DELAY_TAPS-1];

  // Step the generator and push the new word into the selected channel's line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= NOISE_SEED;
      for (int i = 0; i < DELAY_TAPS; i++) begin
        hist_l_q[i] <= '0;
        hist_r_q[i] <= '0;
      end
    end else if (step_i) begin
      gen_q <= gen_next;
      if (chan_i) begin
        for (int i = DELAY_TAPS - 1; i > 0; i--) begin
          hist_r_q[i] <= hist_r_q[i-1];
        end
        hist_r_q[0] <= cur_o;
      end else begin
        for (int i = DELAY_TAPS - 1; i > 0; i--) begin
          hist_l_q[i] <= hist_l_q[i-1];
        end
        hist_l_q[0] <= cur_o;
      end
    end
  end

  // A xorshift generator started from a nonzero seed never reaches zero.
  `HDRQ_ALWAYS(a_gen_nonzero, gen_q != 32'd0, "noise generator reached the all-zero state")
  // Without a step the generator holds its value.
  `HDRQ_NEXT(a_gen_hold, !step_i, $stable(gen_q), "noise generator moved without a step")

endmodule

`default_nettype wire

[src/highpass_dither_requantizer_core.sv]
// Usage
// Input channel: in_valid_i/in_ready_o move one stereo word (sample_left_i,
// sample_right_i, signed Q1.23). Output channel: out_valid_o/out_ready_i move one
// word (out_left_o, out_right_o, signed Q2.23, saturated). The configuration port
// writes scale_factor (index 0) or out_reciprocal (index 1) whenever cfg_we_i is high.
// Timing: a new word is accepted only once the previous one is in the output register.
// Both channels go through one shared multiplier, four sequencer steps per
// multiplication of a channel (two chunk products, one accumulate, one level or
// rounding step), and each channel needs two multiplications.
// Reset: the configuration registers return to their reset values, the noise
// generator to its seed and the dither history to zero. The block leaves reset ready.
// Stall: a finished word waits in the output register; the block still accepts and
// computes the next word, then holds it until the output register is taken.
// Depends on hdrq_pkg, hdrq_mac, hdrq_dither and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "highpass_dither_requantizer_core_macros.svh"

module highpass_dither_requantizer_core
  import hdrq_pkg::*;
#(
  parameter int DELAY_TAPS  = DEF_DELAY_TAPS,
  parameter int DITHER_BITS = DEF_DITHER_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_left_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_right_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS:0]   out_left_o,
  output logic signed [SAMPLE_BITS:0]   out_right_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [REG_W-1:0]              cfg_data_i
);

  // Derived widths of the fixed-point path.
  localparam int SB  = SAMPLE_BITS;
  localparam int OW  = SB + 1;
  localparam int PW  = SB + SCALE_W;
  localparam int K   = SB - 1 + SCALE_FRAC - DITHER_BITS;
  localparam int KL  = (K < 0) ? -K : 0;
  localparam int KR  = (K > 0) ? K : 0;
  localparam int TW  = PW + KL - KR;
  localparam int SW  = TW + 1;
  localparam int LW  = SW - DITHER_BITS;
  localparam int MW  = (SB > LW) ? SB : LW;
  localparam int AW  = MW + REG_W;
  localparam int RW  = AW + 1;
  localparam int OS  = RECIP_FRAC - (SB - 1);

  localparam logic signed [RW-1:0] OUT_MAX = (RW'(1) <<< SB) - RW'(1);
  localparam logic signed [RW-1:0] OUT_MIN = -(RW'(1) <<< SB);
  localparam logic signed [RW-1:0] RND_HALF = RW'(1) <<< (OS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_LVL  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ch_q, ch_d;
  logic       phase_q, phase_d;

  logic [SCALE_W-1:0] scale_q;
  logic [RECIP_W-1:0] recip_q;

  logic signed [SB-1:0] samp_l_q, samp_r_q;
  logic signed [LW-1:0] lvl_q;
  logic signed [OW-1:0] res_l_q;
  logic signed [OW-1:0] hold_r_q;
  logic signed [OW-1:0] word_l_q, word_r_q;
  logic                 out_valid_q;

  logic                   in_acc;
  logic                   out_load;
  mac_ctrl_t              mac_ctrl;
  logic signed [MW-1:0]   mac_a;
  logic [CHUNK_W-1:0]     mac_chunk;
  logic signed [AW-1:0]   acc;
  logic [REG_W-1:0]       coef;
  logic                   dith_step;
  logic [DITHER_BITS-1:0] dith_cur, dith_old;

  logic signed [PW-1:0]    prod_s;
  logic signed [PW+KL-1:0] prod_l;
  logic signed [TW-1:0]    prod_t;
  logic signed [SW-1:0]    lvl_sum;
  logic signed [LW-1:0]    lvl_d;
  logic signed [RW-1:0]    rnd_sum;
  logic signed [RW-1:0]    rnd_q;
  logic signed [OW-1:0]    sat_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      recip_q <= RECIP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_RECIP: recip_q <= cfg_data_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: scale pass, level step, reciprocal pass, rounding, per channel.
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    phase_d  = phase_q;
    mac_ctrl = '0;
    dith_step = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MUL0;
          ch_d    = 1'b0;
          phase_d = 1'b0;
        end
      end
      S_MUL0: begin
        mac_ctrl.mul_en = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        mac_ctrl.acc_add = 1'b1;
        state_d = phase_q ? S_RND : S_LVL;
      end
      S_LVL: begin
        dith_step = 1'b1;
        phase_d   = 1'b1;
        state_d   = S_MUL0;
      end
      S_RND: begin
        phase_d = 1'b0;
        if (ch_q) begin
          state_d = S_OUT;
        end else begin
          ch_d    = 1'b1;
          state_d = S_MUL0;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      phase_q <= phase_d;
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_l_q <= sample_left_i;
      samp_r_q <= sample_right_i;
    end
  end

  // Multiplier operands: sample times scale, then level times reciprocal.
  assign coef      = phase_q ? REG_W'(recip_q) : REG_W'(scale_q);
  assign mac_chunk = (state_q == S_MUL0) ? coef[CHUNK_W-1:0] : coef[REG_W-1:CHUNK_W];
  assign mac_a     = phase_q ? MW'(lvl_q) : (ch_q ? MW'(samp_r_q) : MW'(samp_l_q));

  hdrq_mac #(
    .A_W (MW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (mac_a),
    .chunk_i (mac_chunk),
    .acc_o   (acc)
  );

  hdrq_dither #(
    .DELAY_TAPS  (DELAY_TAPS),
    .DITHER_BITS (DITHER_BITS)
  ) u_dither (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (dith_step),
    .chan_i (ch_q),
    .cur_o  (dith_cur),
    .old_o  (dith_old)
  );

  // Level: add new and remove old dither on the scaled sample, then floor to the dither grid.
  assign prod_s  = $signed(acc[PW-1:0]);
  assign prod_l  = (PW+KL)'(prod_s) <<< KL;
  assign prod_t  = TW'(prod_l >>> KR);
  assign lvl_sum = SW'(prod_t) + SW'($signed({1'b0, dith_cur}))
                 - SW'($signed({1'b0, dith_old}));
  assign lvl_d   = LW'(lvl_sum >>> DITHER_BITS);

  always_ff @(posedge clk_i) begin
    if (state_q == S_LVL) begin
      lvl_q <= lvl_d;
    end
  end

  // Output: round to nearest with ties upward, then saturate.
  assign rnd_sum = RW'(acc) + RND_HALF;
  assign rnd_q   = rnd_sum >>> OS;

  always_comb begin
    if (rnd_q > OUT_MAX) begin
      sat_d = OW'(OUT_MAX);
    end else if (rnd_q < OUT_MIN) begin
      sat_d = OW'(OUT_MIN);
    end else begin
      sat_d = OW'(rnd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_RND) && !ch_q) begin
      res_l_q <= sat_d;
    end
  end

  // The right result is kept until the output register is free.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_RND) && ch_q) begin
      hold_r_q <= sat_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      word_l_q <= res_l_q;
      word_r_q <= hold_r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = word_l_q;
  assign out_right_o = word_r_q;

  // An accepted word starts the scale pass of the left channel.
  `HDRQ_NEXT(a_start_left, in_acc, (state_q == S_MUL0) && !ch_q && !phase_q,
    "accepted word did not start the left channel")
  // The end of the left channel starts the right channel's scale pass.
  `HDRQ_NEXT(a_left_to_right, (state_q == S_RND) && !ch_q,
    (state_q == S_MUL0) && ch_q && !phase_q, "right channel did not follow the left")
  // A finished word waits while the previous one is still unclaimed.
  `HDRQ_NEXT(a_stall_wait, (state_q == S_OUT) && out_valid_q && !out_ready_i,
    state_q == S_OUT, "result overwrote an unclaimed word")
  // The level step only follows an accumulate of the scale pass.
  `HDRQ_NEXT(a_lvl_after_add, (state_q == S_ADD) && !phase_q, state_q == S_LVL,
    "level step skipped after the scale pass")

endmodule

`default_nettype wire
